### hdl/der_signature_to_raw_rs_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DER signature converter
// Each macro checks one implication on the rising edge of clock, outside reset.
// ----------------------------------------------------------------------------
`ifndef DER_SIGNATURE_TO_RAW_RS_ASSERT_SVH
`define DER_SIGNATURE_TO_RAW_RS_ASSERT_SVH

// Same-cycle implication.
`define DSR_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsr assertion failed");

// Next-cycle implication.
`define DSR_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsr assertion failed");

`endif

### hdl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Types and constants shared by the DER signature to raw R||S converter.
// ----------------------------------------------------------------------------
package dsr_pkg;

   localparam int DEF_MAX_DER_BYTES = 72;
   localparam int DEF_MIN_DER_BYTES = 70;
   localparam int DER_BYTES_HIGH    = 72;
   localparam int SCALAR_BYTES      = 32;
   localparam int RAW_BYTES         = 2 * SCALAR_BYTES;

   localparam int POS_W  = $clog2(DER_BYTES_HIGH + 1);
   localparam int PAD_W  = $clog2(SCALAR_BYTES);
   localparam int RAW_W  = $clog2(RAW_BYTES);
   localparam int LEN_W  = 7;

   localparam int NUM_BANKS  = 2;
   localparam int DESC_DEPTH = 2;
   localparam int QCNT_W     = $clog2(DESC_DEPTH + 1);
   localparam int OUT_DEPTH  = 4;

   localparam logic [7:0] SEQ_TAG   = 8'h30;
   localparam logic [7:0] INT_TAG   = 8'h02;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] FF_BYTE   = 8'hff;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [7:0] CAPACITY_RESET = 8'd64;

   typedef struct packed {
      logic [7:0] der_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] sig_byte;
      logic       ok;
      logic       run_end;
   } rsp_type;

   // One scalar: zero flag, left padding and store index of byte 0 minus padding.
   typedef struct packed {
      logic             zero;
      logic [PAD_W-1:0] pad;
      logic [POS_W-1:0] base;
   } scal_type;

   typedef struct packed {
      logic     ok;
      logic     bank;
      scal_type r;
      scal_type s;
   } desc_type;

endpackage

### hdl/dsr_ram.sv
// ----------------------------------------------------------------------------
// dsr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dsr_front.sv
// ----------------------------------------------------------------------------
// dsr_front
// Takes encoded bytes, writes them to the current bank and parses the DER
// structure on the fly; the final byte yields one descriptor.
// ----------------------------------------------------------------------------
module dsr_front #(
   parameter int MAX_DER_BYTES = dsr_pkg::DEF_MAX_DER_BYTES,
   parameter int MIN_DER_BYTES = dsr_pkg::DEF_MIN_DER_BYTES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  dsr_pkg::req_type                       req_data,
   input  logic [7:0]                             capacity,
   input  logic [dsr_pkg::QCNT_W-1:0]             q_count,
   input  logic                                   back_busy,
   output logic                                   wr_en,
   output logic [$clog2(2*MAX_DER_BYTES)-1:0]     wr_addr,
   output logic [7:0]                             wr_data,
   output logic                                   desc_push,
   output dsr_pkg::desc_type                      desc_data
);

   localparam int AW = $clog2(2 * MAX_DER_BYTES);

   typedef enum logic [2:0] {
      PH_SEQ_TAG,
      PH_SEQ_LEN,
      PH_TAG,
      PH_LEN,
      PH_BODY,
      PH_DONE
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic                        sel_ff, sel_in;
   logic                        bank_ff, bank_in;
   logic [dsr_pkg::POS_W-1:0]   count_ff, count_in;
   logic                        too_long_ff, too_long_in;
   logic                        bad_ff, bad_in;
   logic                        first_ff, first_in;
   logic                        second_ff, second_in;
   logic                        nz_ff, nz_in;
   logic                        neg_ff, neg_in;
   logic                        b0z_ff, b0z_in;
   logic                        b0f_ff, b0f_in;
   logic [7:0]                  seq_len_ff, seq_len_in;
   logic [dsr_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [dsr_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic [dsr_pkg::LEN_W-1:0]   z_ff, z_in;
   logic [dsr_pkg::POS_W-1:0]   start_ff, start_in;
   dsr_pkg::scal_type           scal_ff [2];
   dsr_pkg::scal_type           scal_in [2];

   logic [dsr_pkg::QCNT_W:0]    busy_banks;
   logic                        accept;
   logic                        store;
   logic [7:0]                  b;
   logic [dsr_pkg::POS_W-1:0]   n;
   logic                        ok;

   function automatic dsr_pkg::scal_type finish_scalar(
      input logic [dsr_pkg::LEN_W-1:0] len,
      input logic [dsr_pkg::LEN_W-1:0] zeros,
      input logic                      nonzero,
      input logic                      negative,
      input logic [dsr_pkg::POS_W-1:0] start
   );
      logic [dsr_pkg::LEN_W-1:0] eff;
      logic [dsr_pkg::LEN_W-1:0] pad_w;
      dsr_pkg::scal_type         s;
      eff    = len - zeros;
      pad_w  = dsr_pkg::LEN_W'(dsr_pkg::SCALAR_BYTES) - eff;
      s.zero = negative || !nonzero || (eff > dsr_pkg::LEN_W'(dsr_pkg::SCALAR_BYTES));
      s.pad  = pad_w[dsr_pkg::PAD_W-1:0];
      s.base = start - dsr_pkg::POS_W'(s.pad);
      return s;
   endfunction

   // A new signature may only be filled while at most the other bank is in use.
   assign busy_banks = (dsr_pkg::QCNT_W+1)'(q_count) + (dsr_pkg::QCNT_W+1)'(back_busy);
   assign full       = busy_banks >= (dsr_pkg::QCNT_W+1)'(dsr_pkg::NUM_BANKS);
   assign accept     = push && !full;
   assign store      = accept && (count_ff < dsr_pkg::POS_W'(MAX_DER_BYTES));
   assign b          = req_data.der_byte;
   assign n          = count_ff + dsr_pkg::POS_W'(1);

   assign wr_en   = store;
   assign wr_addr = AW'(count_ff) + (bank_ff ? AW'(MAX_DER_BYTES) : '0);
   assign wr_data = b;

   always_comb begin
      phase_in    = phase_ff;
      sel_in      = sel_ff;
      bank_in     = bank_ff;
      count_in    = count_ff;
      too_long_in = too_long_ff;
      bad_in      = bad_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      nz_in       = nz_ff;
      neg_in      = neg_ff;
      b0z_in      = b0z_ff;
      b0f_in      = b0f_ff;
      seq_len_in  = seq_len_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      z_in        = z_ff;
      start_in    = start_ff;
      scal_in     = scal_ff;
      ok          = 1'b0;
      desc_push   = 1'b0;

      if (store) begin
         count_in = count_ff + dsr_pkg::POS_W'(1);
         case (phase_ff)
            PH_SEQ_TAG: begin
               if (b != dsr_pkg::SEQ_TAG) bad_in = 1'b1;
               phase_in = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
               seq_len_in = b;
               if (b[7] || b == dsr_pkg::ZERO_BYTE) bad_in = 1'b1;
               phase_in = PH_TAG;
               sel_in   = 1'b0;
            end
            PH_TAG: begin
               if (b != dsr_pkg::INT_TAG) bad_in = 1'b1;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (b[7] || b == dsr_pkg::ZERO_BYTE) bad_in = 1'b1;
               len_in    = b[dsr_pkg::LEN_W-1:0];
               rem_in    = b[dsr_pkg::LEN_W-1:0];
               first_in  = 1'b1;
               second_in = 1'b0;
               nz_in     = 1'b0;
               neg_in    = 1'b0;
               z_in      = '0;
               phase_in  = PH_BODY;
            end
            PH_BODY: begin
               rem_in = rem_ff - dsr_pkg::LEN_W'(1);
               if (first_ff) begin
                  b0z_in    = (b == dsr_pkg::ZERO_BYTE);
                  b0f_in    = (b == dsr_pkg::FF_BYTE);
                  neg_in    = b[7];
                  first_in  = 1'b0;
                  second_in = 1'b1;
               end
               // reject redundant sign padding
               if (second_ff) begin
                  if ((b0z_ff && !b[7]) || (b0f_ff && b[7])) bad_in = 1'b1;
                  second_in = 1'b0;
               end
               // skip leading zeros
               if (!nz_ff) begin
                  if (b == dsr_pkg::ZERO_BYTE) begin
                     z_in = z_ff + dsr_pkg::LEN_W'(1);
                  end else begin
                     nz_in    = 1'b1;
                     start_in = count_ff;
                  end
               end
               if (rem_ff == dsr_pkg::LEN_W'(1)) begin
                  scal_in[sel_ff] = finish_scalar(len_ff, z_in, nz_in, neg_in, start_in);
                  if (sel_ff) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_TAG;
                     sel_in   = 1'b1;
                  end
               end
            end
            PH_DONE: begin
               bad_in = 1'b1;
            end
            default: begin
               bad_in = 1'b1;
            end
         endcase
      end else if (accept) begin
         too_long_in = 1'b1;
      end

      if (accept && req_data.final_byte) begin
         ok = store && !too_long_ff && !bad_in && (phase_in == PH_DONE)
            && (n >= dsr_pkg::POS_W'(MIN_DER_BYTES))
            && ((9'(seq_len_ff) + 9'd2) == 9'(n))
            && (capacity >= 8'(dsr_pkg::RAW_BYTES));
         desc_push   = 1'b1;
         count_in    = '0;
         too_long_in = 1'b0;
         bad_in      = 1'b0;
         phase_in    = PH_SEQ_TAG;
         sel_in      = 1'b0;
         bank_in     = ~bank_ff;
      end
   end

   always_comb begin
      desc_data.ok   = ok;
      desc_data.bank = bank_ff;
      desc_data.r    = scal_in[0];
      desc_data.s    = scal_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEQ_TAG;
         sel_ff      <= 1'b0;
         bank_ff     <= 1'b0;
         count_ff    <= '0;
         too_long_ff <= 1'b0;
         bad_ff      <= 1'b0;
         first_ff    <= 1'b0;
         second_ff   <= 1'b0;
         nz_ff       <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         sel_ff      <= sel_in;
         bank_ff     <= bank_in;
         count_ff    <= count_in;
         too_long_ff <= too_long_in;
         bad_ff      <= bad_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         nz_ff       <= nz_in;
      end
      neg_ff     <= neg_in;
      b0z_ff     <= b0z_in;
      b0f_ff     <= b0f_in;
      seq_len_ff <= seq_len_in;
      len_ff     <= len_in;
      rem_ff     <= rem_in;
      z_ff       <= z_in;
      start_ff   <= start_in;
      scal_ff    <= scal_in;
   end

endmodule

### hdl/dsr_queue.sv
// ----------------------------------------------------------------------------
// dsr_queue
// Short descriptor queue between the parsing front and the output back.
// ----------------------------------------------------------------------------
module dsr_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  dsr_pkg::desc_type              push_data,
   input  logic                           pop,
   output logic                           valid,
   output dsr_pkg::desc_type              head,
   output logic [dsr_pkg::QCNT_W-1:0]     count
);

   localparam int PW = $clog2(dsr_pkg::DESC_DEPTH);

   dsr_pkg::desc_type             mem_ff [dsr_pkg::DESC_DEPTH];
   logic [PW-1:0]                 wp_ff, wp_in;
   logic [PW-1:0]                 rp_ff, rp_in;
   logic [dsr_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                          do_pop;

   assign valid  = cnt_ff != '0;
   assign do_pop = pop && valid;
   assign head   = mem_ff[rp_ff];
   assign count  = cnt_ff;

   always_comb begin
      wp_in  = push ? wp_ff + PW'(1) : wp_ff;
      rp_in  = do_pop ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + dsr_pkg::QCNT_W'(push) - dsr_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

### hdl/dsr_back.sv
// ----------------------------------------------------------------------------
// dsr_back
// Walks one descriptor at a time, reads scalar bytes from the store and
// fills a small result queue; a reject gives a single word.
// ----------------------------------------------------------------------------
`include "der_signature_to_raw_rs_assert.svh"

module dsr_back #(
   parameter int MAX_DER_BYTES = dsr_pkg::DEF_MAX_DER_BYTES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   desc_valid,
   input  dsr_pkg::desc_type                      desc_head,
   output logic                                   desc_pop,
   output logic                                   busy,
   output logic                                   rd_en,
   output logic [$clog2(2*MAX_DER_BYTES)-1:0]     rd_addr,
   input  logic [7:0]                             rd_data,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output dsr_pkg::rsp_type                       rsp_data
);

   localparam int AW = $clog2(2 * MAX_DER_BYTES);
   localparam int OPW = $clog2(dsr_pkg::OUT_DEPTH);
   localparam int OCW = $clog2(dsr_pkg::OUT_DEPTH + 1);

   logic                           active_ff;
   dsr_pkg::desc_type              desc_ff;
   logic [dsr_pkg::RAW_W-1:0]      k_ff;
   logic                           pv_ff;
   logic                           pram_ff;
   logic                           pok_ff;
   logic                           pend_ff;
   dsr_pkg::rsp_type               fifo_ff [dsr_pkg::OUT_DEPTH];
   logic [OPW-1:0]                 wp_ff;
   logic [OPW-1:0]                 rp_ff;
   logic [OCW-1:0]                 cnt_ff, cnt_in;

   logic                           space;
   logic                           issue;
   logic                           last;
   logic                           use_ram;
   dsr_pkg::scal_type              sc;
   logic [dsr_pkg::PAD_W-1:0]      j;
   logic [dsr_pkg::POS_W-1:0]      idx;
   logic                           fpop;
   dsr_pkg::rsp_type               fdata;

   assign desc_pop = !active_ff && desc_valid;
   assign busy     = active_ff;

   // reserve a slot for the word still in the read stage
   assign space = (cnt_ff + OCW'(pv_ff)) < OCW'(dsr_pkg::OUT_DEPTH);
   assign issue = active_ff && space;

   always_comb begin
      sc      = k_ff[dsr_pkg::RAW_W-1] ? desc_ff.s : desc_ff.r;
      j       = k_ff[dsr_pkg::PAD_W-1:0];
      use_ram = desc_ff.ok && !sc.zero && (j >= sc.pad);
      idx     = sc.base + dsr_pkg::POS_W'(j);
      last    = !desc_ff.ok || (k_ff == dsr_pkg::RAW_W'(dsr_pkg::RAW_BYTES - 1));
   end

   assign rd_en   = issue && use_ram;
   assign rd_addr = AW'(idx) + (desc_ff.bank ? AW'(MAX_DER_BYTES) : '0);

   assign rsp_empty = cnt_ff == '0;
   assign fpop      = rsp_pop && !rsp_empty;
   assign rsp_data  = fifo_ff[rp_ff];

   always_comb begin
      fdata.sig_byte = pram_ff ? rd_data : dsr_pkg::ZERO_BYTE;
      fdata.ok       = pok_ff;
      fdata.run_end  = pend_ff;
      cnt_in         = cnt_ff + OCW'(pv_ff) - OCW'(fpop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pv_ff     <= 1'b0;
         wp_ff     <= '0;
         rp_ff     <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
      end else begin
         if (desc_pop) begin
            active_ff <= 1'b1;
            k_ff      <= '0;
         end else if (issue) begin
            k_ff <= k_ff + dsr_pkg::RAW_W'(1);
            if (last) active_ff <= 1'b0;
         end
         pv_ff  <= issue;
         cnt_ff <= cnt_in;
         if (pv_ff) wp_ff <= wp_ff + OPW'(1);
         if (fpop) rp_ff <= rp_ff + OPW'(1);
      end
      if (desc_pop) desc_ff <= desc_head;
      pram_ff <= use_ram;
      pok_ff  <= desc_ff.ok;
      pend_ff <= last;
      if (pv_ff) fifo_ff[wp_ff] <= fdata;
   end

   `DSR_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_ff <= OCW'(dsr_pkg::OUT_DEPTH))
   `DSR_ASSERT_NXT(a_issue_lands, issue, pv_ff)
   `DSR_ASSERT_IMP(a_reject_ends, pv_ff && !pok_ff, pend_ff && !pram_ff)
   `DSR_ASSERT_IMP(a_reject_head, !rsp_empty && !rsp_data.ok, rsp_data.run_end)

endmodule

### hdl/der_signature_to_raw_rs.sv
// ----------------------------------------------------------------------------
// der_signature_to_raw_rs
// DER-encoded ECDSA signature to raw R||S converter, top level.
// ----------------------------------------------------------------------------
// Push the encoded signature on req_* one byte per word, final_byte set on
// the last one. A signature of accepted form comes out on rsp_* as 64 words,
// R then S, right-aligned big-endian, ok set, run_end on the last; any other
// encoding gives one word with ok clear, sig_byte zero and run_end set.
// Input takes one byte per cycle, while req_full is low, into one of two
// store banks. The final byte's descriptor passes through a descriptor queue
// to the back, which reads the store into the result queue and then delivers
// one word per cycle while rsp_pop is held. Two signatures may be outstanding
// at once; req_full rises after the final byte of a second one until the back
// has issued its last store read of the earlier one. A stalled receiver
// fills the four-word result queue, then the back waits and in turn the
// front. Reset empties every queue and restores capacity to 64; the byte
// store needs no clearing pass. The capacity register sits at address 0 of
// the csr_* port; the user must write it only while the block is idle, and
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module der_signature_to_raw_rs #(
   parameter int MAX_DER_BYTES = dsr_pkg::DEF_MAX_DER_BYTES,
   parameter int MIN_DER_BYTES = dsr_pkg::DEF_MIN_DER_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  dsr_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output dsr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dsr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dsr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dsr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(2 * MAX_DER_BYTES);

   logic [7:0]                   capacity_ff;
   logic                         csr_write;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [7:0]                   wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [7:0]                   rd_data;

   logic                         q_push;
   dsr_pkg::desc_type            q_push_data;
   logic                         q_pop;
   logic                         q_valid;
   dsr_pkg::desc_type            q_head;
   logic [dsr_pkg::QCNT_W-1:0]   q_count;
   logic                         back_busy;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == dsr_pkg::CSR_CAPACITY)
                       ? dsr_pkg::CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= dsr_pkg::CAPACITY_RESET;
      end else if (csr_write && csr_paddr == dsr_pkg::CSR_CAPACITY) begin
         capacity_ff <= csr_pwdata[7:0];
      end
   end

   dsr_ram #(
      .WIDTH (8),
      .DEPTH (2 * MAX_DER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dsr_front #(
      .MAX_DER_BYTES (MAX_DER_BYTES),
      .MIN_DER_BYTES (MIN_DER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .q_count   (q_count),
      .back_busy (back_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .desc_push (q_push),
      .desc_data (q_push_data)
   );

   dsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   dsr_back #(
      .MAX_DER_BYTES (MAX_DER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (q_valid),
      .desc_head  (q_head),
      .desc_pop   (q_pop),
      .busy       (back_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

### verif/der_signature_to_raw_rs_tb.sv
// ----------------------------------------------------------------------------
// der_signature_to_raw_rs_tb
// Self-checking bench for the DER signature to raw R||S converter.
// ----------------------------------------------------------------------------
// Signatures are built as byte queues and pushed one word per byte, with the
// final mark on the last. A table of hand-made encodings comes first: scalar
// extremes, sign and length cases, and one of each malformed form, with the
// reject word typed in. Random signatures follow, mostly well formed with
// random scalars, some corrupted and some pure noise, over several capacity
// settings and idle patterns. A predictor in the bench keeps its own byte
// store and builds the expected R||S words; every popped word is compared
// with the oldest of them. A watchdog ends a run in which nothing moves.
// ----------------------------------------------------------------------------
module der_signature_to_raw_rs_tb;
   import dsr_pkg::*;

   localparam int         STORE_BYTES   = DEF_MAX_DER_BYTES;
   localparam int         MIN_BYTES     = DEF_MIN_DER_BYTES;
   localparam int         STALL_LIMIT   = 4000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 16;
   localparam logic [7:0] LONG_FORM     = 8'h80;
   localparam rsp_type    REJECT_WORD   = '{sig_byte: 8'h00, ok: 1'b0, run_end: 1'b1};

   typedef struct packed {
      int         r_len;
      logic [7:0] r0;
      logic [7:0] r1;
      int         s_len;
      logic [7:0] s0;
      logic [7:0] s1;
      int         tail;
      int         poke_pos;
      logic [7:0] poke_val;
      int         resize;
      bit         reject;
   } der_case_t;

   // r_len r0 r1 | s_len s0 s1 | tail | poke pos, value | resize | reject
   localparam der_case_t DER_CASES [22] = '{
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0, -1, 8'h00,   0, 1'b0},
      '{33, 8'h00, 8'hff, 33, 8'h00, 8'hff, 0, -1, 8'h00,   0, 1'b0},
      '{33, 8'h00, 8'h80, 32, 8'h01, 8'h00, 0, -1, 8'h00,   0, 1'b0},
      '{32, 8'h80, 8'h00, 32, 8'h7f, 8'hff, 0, -1, 8'h00,   0, 1'b0},
      '{34, 8'h01, 8'h23, 32, 8'h40, 8'h00, 0, -1, 8'h00,   0, 1'b0},
      '{ 1, 8'h00, 8'h00, 63, 8'h12, 8'h34, 0, -1, 8'h00,   0, 1'b0},
      '{ 1, 8'hff, 8'h00, 63, 8'h00, 8'h81, 0, -1, 8'h00,   0, 1'b0},
      '{62, 8'h11, 8'h22,  2, 8'h00, 8'h80, 0, -1, 8'h00,   0, 1'b0},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  0, 8'h31,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  1, 8'h45,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  1, 8'h81,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  2, 8'h03,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  3, 8'ha0,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0,  3, 8'h00,   0, 1'b1},
      '{32, 8'h00, 8'h01, 32, 8'h7f, 8'hff, 0, -1, 8'h00,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'hff, 8'h80, 0, -1, 8'h00,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0, -1, 8'h00,  -1, 1'b1},
      '{33, 8'h00, 8'hff, 33, 8'h00, 8'hff, 0, -1, 8'h00,   3, 1'b1},
      '{66, 8'h01, 8'h02, -1, 8'h00, 8'h00, 0, -1, 8'h00,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 31, 8'h7f, 8'hff, 1, -1, 8'h00,   0, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0, -1, 8'h00, -69, 1'b1},
      '{32, 8'h7f, 8'hff, 32, 8'h7f, 8'hff, 0, 37, 8'h21,   0, 1'b1}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_push    = 1'b0;
   logic                  req_full;
   req_type               req_data    = '0;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [7:0] der_store [STORE_BYTES];
   int         der_count    = 0;
   bit         der_overflow = 1'b0;
   logic [7:0] capacity     = CAPACITY_RESET;
   rsp_type    raw_word_q [$];

   logic [7:0] sig_q [$];
   int         fail_count    = 0;
   int         send_idle_pct = 11;
   int         recv_idle_pct = 46;
   bit         hold_request  = 1'b0;
   bit         reject_typed  = 1'b0;
   int         hold_left     = 0;
   bit         hold_taken    = 1'b0;
   int         stall_cycles  = 0;

   der_signature_to_raw_rs u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Parse one INTEGER at pos; value is the scalar right-aligned, or zero.
   function automatic bit scan_integer(inout int pos, input int n,
                                       output logic [8*SCALAR_BYTES-1:0] value);
      int         p;
      int         len;
      logic [7:0] b0;
      logic [7:0] b1;
      bit         neg;
      value = '0;
      p = pos;
      if (p >= n || der_store[p] != INT_TAG) return 1'b0;
      p++;
      if (p >= n) return 1'b0;
      len = der_store[p];
      p++;
      if ((len & LONG_FORM) != 0) return 1'b0;
      if (len == 0 || p + len > n) return 1'b0;
      b0 = der_store[p];
      b1 = (len > 1) ? der_store[p+1] : ZERO_BYTE;
      if (b0 == ZERO_BYTE && len > 1 && !b1[7]) return 1'b0;
      if (b0 == FF_BYTE && len > 1 && b1[7]) return 1'b0;
      neg = b0[7];
      while (len > 0 && der_store[p] == ZERO_BYTE) begin
         len--;
         p++;
      end
      if (!neg && len <= SCALAR_BYTES && len > 0)
         for (int i = 0; i < len; i++) value = (value << 8) | der_store[p+i];
      pos = p + len;
      return 1'b1;
   endfunction

   function automatic bit decode_signature(input int n, output logic [8*RAW_BYTES-1:0] raw);
      int                        pos;
      logic [8*SCALAR_BYTES-1:0] r_val;
      logic [8*SCALAR_BYTES-1:0] s_val;
      raw = '0;
      if (n < MIN_BYTES || n > STORE_BYTES) return 1'b0;
      if (capacity < RAW_BYTES) return 1'b0;
      if (der_store[0] != SEQ_TAG) return 1'b0;
      if (der_store[1][7] || der_store[1] == 0 || 2 + der_store[1] != n) return 1'b0;
      pos = 2;
      if (!scan_integer(pos, n, r_val)) return 1'b0;
      if (!scan_integer(pos, n, s_val)) return 1'b0;
      raw = {r_val, s_val};
      return pos == n;
   endfunction

   function automatic void predict_word(input logic [7:0] b, input logic fin);
      logic [8*RAW_BYTES-1:0] raw;
      bit                     ok;
      rsp_type                w;
      if (der_count < STORE_BYTES) begin
         der_store[der_count] = b;
         der_count++;
      end else begin
         der_overflow = 1'b1;
      end
      if (!fin) return;
      ok = decode_signature(der_count, raw) && !der_overflow;
      der_count = 0;
      der_overflow = 1'b0;
      if (reject_typed || !ok) begin
         raw_word_q.push_back(REJECT_WORD);
      end else begin
         for (int k = 0; k < RAW_BYTES; k++) begin
            w.sig_byte = raw[8*(RAW_BYTES-1-k) +: 8];
            w.ok = 1'b1;
            w.run_end = (k == RAW_BYTES - 1);
            raw_word_q.push_back(w);
         end
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{der_byte: b, final_byte: fin};
      do @(posedge clock); while (req_full);
      predict_word(b, fin);
   endtask

   task automatic send_signature();
      for (int i = 0; i < sig_q.size(); i++) send_word(sig_q[i], i == sig_q.size() - 1);
   endtask

   // len < 0 gives the tag alone
   task automatic add_integer(input int len, input logic [7:0] b0, input logic [7:0] b1,
                              input bit random_fill);
      sig_q.push_back(INT_TAG);
      if (len < 0) return;
      sig_q.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
         if (i == 0) sig_q.push_back(b0);
         else if (i == 1 || !random_fill) sig_q.push_back(b1);
         else sig_q.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic build_sig(input int r_len, input logic [7:0] r0, input logic [7:0] r1,
                            input int s_len, input logic [7:0] s0, input logic [7:0] s1,
                            input int tail, input bit random_fill);
      sig_q.delete();
      sig_q.push_back(SEQ_TAG);
      sig_q.push_back(ZERO_BYTE);
      add_integer(r_len, r0, r1, random_fill);
      add_integer(s_len, s0, s1, random_fill);
      repeat (tail) sig_q.push_back(8'($urandom_range(255)));
      sig_q[1] = 8'(sig_q.size() - 2);
   endtask

   task automatic reshape(input int poke_pos, input logic [7:0] poke_val, input int resize);
      if (poke_pos >= 0 && poke_pos < sig_q.size()) sig_q[poke_pos] = poke_val;
      if (resize > 0) begin
         repeat (resize) sig_q.push_back(8'($urandom_range(255)));
      end else begin
         repeat (-resize) if (sig_q.size() > 1) sig_q.pop_back();
      end
   endtask

   task automatic pick_lead(output logic [7:0] b0, output logic [7:0] b1);
      b1 = 8'($urandom_range(255));
      case ($urandom_range(4))
         0: b0 = 8'($urandom_range(127, 1));
         1: begin
            b0 = ZERO_BYTE;
            b1 = 8'($urandom_range(255, 128));
         end
         2: b0 = 8'($urandom_range(254, 128));
         3: b0 = ZERO_BYTE;
         default: b0 = FF_BYTE;
      endcase
   endtask

   task automatic make_random_signature();
      int         mode;
      int         r_len;
      int         s_len;
      int         pos;
      logic [7:0] val;
      logic [7:0] r0;
      logic [7:0] r1;
      logic [7:0] s0;
      logic [7:0] s1;
      mode = $urandom_range(99);
      if (mode >= 90) begin
         sig_q.delete();
         repeat ($urandom_range(80, 1)) sig_q.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(9) < 7) r_len = $urandom_range(33, 31);
      else r_len = $urandom_range(65, 1);
      s_len = $urandom_range(66, 64) - r_len;
      if (s_len < 1) s_len = 1;
      pick_lead(r0, r1);
      pick_lead(s0, s1);
      build_sig(r_len, r0, r1, s_len, s0, s1, 0, 1'b1);
      if (mode < 70) return;
      // break one thing: a byte, a header field or the length
      case ($urandom_range(3))
         0: reshape($urandom_range(sig_q.size() - 1), 8'($urandom_range(255)), 0);
         1: begin
            pos = $urandom_range(1) ? $urandom_range(3) : 4 + r_len + $urandom_range(1);
            case ($urandom_range(3))
               0: val = SEQ_TAG;
               1: val = INT_TAG;
               2: val = LONG_FORM | 8'($urandom_range(3));
               default: val = 8'($urandom_range(255));
            endcase
            reshape(pos, val, 0);
         end
         2: reshape(-1, ZERO_BYTE, -$urandom_range(3, 1));
         default: reshape(-1, ZERO_BYTE, $urandom_range(3, 1));
      endcase
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         make_random_signature();
         send_signature();
      end
   endtask

   // Drop push, wait for every expected word, then let the back go quiet.
   task automatic settle();
      req_push <= 1'b0;
      while (raw_word_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // psel stays high between back-to-back transfers; the caller drops it.
   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic set_capacity(input logic [7:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      settle();
      csr_access(1'b1, CSR_CAPACITY, CSR_DATA_W'(value), rdata);
      capacity = value;
      csr_access(1'b0, CSR_CAPACITY, '0, rdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata !== CSR_DATA_W'(value)) begin
         $error("capacity readback: expected %0h, actual %0h", value, rdata);
         fail_count++;
      end
   endtask

   // receiver: check each popped word, then choose pop for the next cycle
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (raw_word_q.size() == 0) begin
               $error("result word with nothing expected: %0h", rsp_data);
               fail_count++;
            end else begin
               want = raw_word_q.pop_front();
               if (rsp_data.sig_byte !== want.sig_byte) begin
                  $error("sig_byte: expected %0h, actual %0h", want.sig_byte, rsp_data.sig_byte);
                  fail_count++;
               end
               if (rsp_data.ok !== want.ok) begin
                  $error("ok: expected %0b, actual %0b", want.ok, rsp_data.ok);
                  fail_count++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %0b, actual %0b", want.run_end, rsp_data.run_end);
                  fail_count++;
               end
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DER_CASES[i]) begin
         build_sig(DER_CASES[i].r_len, DER_CASES[i].r0, DER_CASES[i].r1,
                   DER_CASES[i].s_len, DER_CASES[i].s0, DER_CASES[i].s1,
                   DER_CASES[i].tail, 1'b0);
         reshape(DER_CASES[i].poke_pos, DER_CASES[i].poke_val, DER_CASES[i].resize);
         reject_typed = DER_CASES[i].reject;
         send_signature();
      end
      reject_typed = 1'b0;

      run_random(5);
      // stall the receiver long enough to back the block up to its input
      hold_request = 1'b1;
      run_random(35);
      set_capacity(8'd0);
      run_random(10);

      send_idle_pct = 46;
      recv_idle_pct = 11;
      set_capacity(8'd255);
      run_random(40);
      set_capacity(8'd63);
      run_random(10);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_capacity(8'($urandom_range(254, 64)));
      run_random(50);

      settle();
      if (fail_count == 0 && raw_word_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
